FILE: rtl/core/tct_pkg.sv
// Shared constants, defaults and the gray conversion for the centroid tracker.
package tct_pkg;

    localparam int PIX_W          = 8;
    localparam int OUT_W          = 13;
    localparam int QUEUE_DEPTH    = 2;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_COL_W      = 12;
    localparam int DEF_ROW_W      = 12;
    localparam int DEF_CNT_W      = 25;
    localparam int DEF_SUM_W      = 36;
    localparam int GRAY_ACC_W     = 22;

    localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd200;

    function automatic logic [PIX_W-1:0] to_gray(
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] g,
        input logic [PIX_W-1:0] r
    );
        logic [GRAY_ACC_W-1:0] acc;
        acc = 22'd1868 * GRAY_ACC_W'(b) + 22'd9617 * GRAY_ACC_W'(g)
            + 22'd4899 * GRAY_ACC_W'(r) + 22'd8192;
        return acc[GRAY_ACC_W-1:GRAY_ACC_W-PIX_W];
    endfunction

endpackage

FILE: rtl/core/threshold_centroid_tracker.sv
// Threshold centroid tracker top level: front end, frame queue and divider back end.
// The block takes BGR pixels in raster order, converts each to gray with BT.601 weights,
// counts the pixels brighter than the threshold register together with the sums of their
// columns and rows, and on the end-of-frame pixel delivers the truncated mean column and
// row, or -1 for both when no pixel passed. Pixels are taken at one per clock; the front
// end stalls only while the two-entry queue of finished frame totals is full. The back end
// forms each frame result with a restoring divider that yields one quotient bit per cycle
// on the sums, which are 36 bits wide at the default size; an empty frame skips the division.
module threshold_centroid_tracker #(
    parameter int MAX_WIDTH  = tct_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tct_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tct_pkg::PIX_W-1:0]        cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tct_pkg::PIX_W-1:0]        s_blue,
    input  logic [tct_pkg::PIX_W-1:0]        s_green,
    input  logic [tct_pkg::PIX_W-1:0]        s_red,
    input  logic                             s_end_of_line,
    input  logic                             s_end_of_frame,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [tct_pkg::OUT_W-1:0] m_centroid_x,
    output logic signed [tct_pkg::OUT_W-1:0] m_centroid_y
);
    import tct_pkg::*;

    localparam int     CAP    = MAX_WIDTH * MAX_HEIGHT;
    localparam int     COL_W  = $clog2(MAX_WIDTH);
    localparam int     ROW_W  = $clog2(MAX_HEIGHT);
    localparam int     CNT_W  = $clog2(CAP + 1);
    localparam longint SX_MAX = longint'(CAP) * longint'(MAX_WIDTH - 1);
    localparam longint SY_MAX = longint'(CAP) * longint'(MAX_HEIGHT - 1);
    localparam int     SX_W   = $clog2(SX_MAX + 1);
    localparam int     SY_W   = $clog2(SY_MAX + 1);
    localparam int     DIV_W  = (SX_W > SY_W) ? SX_W : SY_W;
    localparam int     Q_W    = CNT_W + SX_W + SY_W;

    logic             t_valid, t_ready;
    logic [CNT_W-1:0] t_count, q_count;
    logic [SX_W-1:0]  t_sum_x, q_sum_x;
    logic [SY_W-1:0]  t_sum_y, q_sum_y;
    logic             q_valid, q_ready;
    logic [Q_W-1:0]   q_in_data, q_out_data;

    tct_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .COL_W     (COL_W),
        .ROW_W     (ROW_W),
        .CNT_W     (CNT_W),
        .SX_W      (SX_W),
        .SY_W      (SY_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_blue        (s_blue),
        .s_green       (s_green),
        .s_red         (s_red),
        .s_end_of_line (s_end_of_line),
        .s_end_of_frame(s_end_of_frame),
        .t_valid       (t_valid),
        .t_ready       (t_ready),
        .t_count       (t_count),
        .t_sum_x       (t_sum_x),
        .t_sum_y       (t_sum_y)
    );

    assign q_in_data = {t_count, t_sum_x, t_sum_y};
    assign {q_count, q_sum_x, q_sum_y} = q_out_data;

    tct_queue #(
        .DATA_W(Q_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (t_valid),
        .in_ready (t_ready),
        .in_data  (q_in_data),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_out_data)
    );

    tct_back #(
        .CNT_W(CNT_W),
        .SX_W (SX_W),
        .SY_W (SY_W),
        .DIV_W(DIV_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_count     (q_count),
        .q_sum_x     (q_sum_x),
        .q_sum_y     (q_sum_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_centroid_x(m_centroid_x),
        .m_centroid_y(m_centroid_y)
    );

endmodule

FILE: rtl/core/tct_front.sv
// Pixel front end: threshold test, position counters and per-frame sums.
module tct_front #(
    parameter int MAX_WIDTH  = tct_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tct_pkg::DEF_MAX_HEIGHT,
    parameter int COL_W      = tct_pkg::DEF_COL_W,
    parameter int ROW_W      = tct_pkg::DEF_ROW_W,
    parameter int CNT_W      = tct_pkg::DEF_CNT_W,
    parameter int SX_W       = tct_pkg::DEF_SUM_W,
    parameter int SY_W       = tct_pkg::DEF_SUM_W
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [tct_pkg::PIX_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [tct_pkg::PIX_W-1:0] s_blue,
    input  logic [tct_pkg::PIX_W-1:0] s_green,
    input  logic [tct_pkg::PIX_W-1:0] s_red,
    input  logic                      s_end_of_line,
    input  logic                      s_end_of_frame,
    output logic                      t_valid,
    input  logic                      t_ready,
    output logic [CNT_W-1:0]          t_count,
    output logic [SX_W-1:0]           t_sum_x,
    output logic [SY_W-1:0]           t_sum_y
);
    import tct_pkg::*;

    localparam int CAP = MAX_WIDTH * MAX_HEIGHT;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);
    localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAP);

    logic [PIX_W-1:0] thr_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_add;
    logic [SX_W-1:0]  sum_x_reg, sum_x_next, sum_x_add;
    logic [SY_W-1:0]  sum_y_reg, sum_y_next, sum_y_add;
    logic             pass;
    logic             accept;

    assign s_ready = t_ready;
    assign accept  = s_valid && s_ready;
    assign t_valid = s_valid && s_end_of_frame;
    assign pass    = (to_gray(s_blue, s_green, s_red) > thr_reg) && (cnt_reg < CNT_CAP);

    always_comb begin
        cnt_add   = cnt_reg;
        sum_x_add = sum_x_reg;
        sum_y_add = sum_y_reg;
        if (pass) begin
            cnt_add   = cnt_reg + CNT_W'(1);
            sum_x_add = sum_x_reg + SX_W'(col_reg);
            sum_y_add = sum_y_reg + SY_W'(row_reg);
        end
        cnt_next   = cnt_add;
        sum_x_next = sum_x_add;
        sum_y_next = sum_y_add;
        col_next   = col_reg;
        row_next   = row_reg;
        priority if (s_end_of_frame) begin
            cnt_next   = '0;
            sum_x_next = '0;
            sum_y_next = '0;
            col_next   = '0;
            row_next   = '0;
        end else if (s_end_of_line) begin
            col_next = '0;
            if (row_reg < ROW_LAST) begin
                row_next = row_reg + ROW_W'(1);
            end
        end else begin
            if (col_reg < COL_LAST) begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    assign t_count = cnt_add;
    assign t_sum_x = sum_x_add;
    assign t_sum_y = sum_y_add;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= THRESHOLD_RESET;
            col_reg   <= '0;
            row_reg   <= '0;
            cnt_reg   <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (accept) begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                cnt_reg   <= cnt_next;
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
            end
        end
    end

endmodule

FILE: rtl/core/tct_queue.sv
// Two-entry queue that holds finished frame totals for the divider.
module tct_queue #(
    parameter int DATA_W = 2 * tct_pkg::DEF_SUM_W + tct_pkg::DEF_CNT_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    import tct_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              push, pop;

    assign in_ready  = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

endmodule

FILE: rtl/core/tct_back.sv
// Back end: bit-serial division of the frame sums and the result register.
module tct_back #(
    parameter int CNT_W = tct_pkg::DEF_CNT_W,
    parameter int SX_W  = tct_pkg::DEF_SUM_W,
    parameter int SY_W  = tct_pkg::DEF_SUM_W,
    parameter int DIV_W = tct_pkg::DEF_SUM_W
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  logic [CNT_W-1:0]                 q_count,
    input  logic [SX_W-1:0]                  q_sum_x,
    input  logic [SY_W-1:0]                  q_sum_y,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [tct_pkg::OUT_W-1:0] m_centroid_x,
    output logic signed [tct_pkg::OUT_W-1:0] m_centroid_y
);
    import tct_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [CNT_W-1:0]  rx_reg, ry_reg, rx_next, ry_next;
    logic [DIV_W-1:0]  qx_reg, qy_reg, qx_next, qy_next;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W:0]    trial_x, trial_y;
    logic [OUT_W-1:0]  cx_reg, cy_reg;
    logic              m_valid_reg;

    assign q_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_centroid_x = $signed(cx_reg);
    assign m_centroid_y = $signed(cy_reg);

    always_comb begin
        trial_x = {rx_reg, qx_reg[DIV_W-1]};
        trial_y = {ry_reg, qy_reg[DIV_W-1]};
        if (trial_x >= {1'b0, den_reg}) begin
            rx_next = CNT_W'(trial_x - {1'b0, den_reg});
            qx_next = {qx_reg[DIV_W-2:0], 1'b1};
        end else begin
            rx_next = trial_x[CNT_W-1:0];
            qx_next = {qx_reg[DIV_W-2:0], 1'b0};
        end
        if (trial_y >= {1'b0, den_reg}) begin
            ry_next = CNT_W'(trial_y - {1'b0, den_reg});
            qy_next = {qy_reg[DIV_W-2:0], 1'b1};
        end else begin
            ry_next = trial_y[CNT_W-1:0];
            qy_next = {qy_reg[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        den_reg  <= q_count;
                        qx_reg   <= DIV_W'(q_sum_x);
                        qy_reg   <= DIV_W'(q_sum_y);
                        rx_reg   <= '0;
                        ry_reg   <= '0;
                        step_reg <= STEP_W'(DIV_W);
                        if (q_count == '0) begin
                            cx_reg      <= '1;
                            cy_reg      <= '1;
                            m_valid_reg <= 1'b1;
                            state_reg   <= ST_OUT;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    rx_reg   <= rx_next;
                    ry_reg   <= ry_next;
                    qx_reg   <= qx_next;
                    qy_reg   <= qy_next;
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_reg == STEP_W'(1)) begin
                        cx_reg      <= OUT_W'(qx_next);
                        cy_reg      <= OUT_W'(qy_next);
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_div_nonzero_den: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> den_reg != '0)
        else $error("Division runs with a zero item count.");

    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> (rx_reg < den_reg) && (ry_reg < den_reg))
        else $error("Partial remainder is not below the divisor.");

    a_valid_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg == (state_reg == ST_OUT))
        else $error("Result valid disagrees with the back-end state.");

    a_div_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> step_reg != '0)
        else $error("Division step counter ran past zero.");
`endif

endmodule

FILE: sim/threshold_centroid_tracker_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the threshold centroid tracker with directed and random frames.
module threshold_centroid_tracker_test;
    import tct_pkg::*;

    typedef struct {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             end_of_line;
        logic             end_of_frame;
    } pixel_t;

    typedef struct {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
    } centroid_t;

    typedef enum int {SHADE_ANY, SHADE_NEAR, SHADE_EXTREME, SHADE_DARK, SHADE_MIXED} shade_t;

    localparam int COL_LAST = DEF_MAX_WIDTH - 1;
    localparam int ROW_LAST = DEF_MAX_HEIGHT - 1;
    localparam int PASS_CAP = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam logic [OUT_W-1:0] NO_OBJECT = '1;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    cfg_wr_en      = 1'b0;
    logic [PIX_W-1:0]        cfg_wr_data    = '0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic [PIX_W-1:0]        s_blue         = '0;
    logic [PIX_W-1:0]        s_green        = '0;
    logic [PIX_W-1:0]        s_red          = '0;
    logic                    s_end_of_line  = 1'b0;
    logic                    s_end_of_frame = 1'b0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic signed [OUT_W-1:0] m_centroid_x;
    logic signed [OUT_W-1:0] m_centroid_y;

    logic [PIX_W-1:0]     gray_thr   = THRESHOLD_RESET;
    logic [DEF_COL_W-1:0] col_pos    = '0;
    logic [DEF_ROW_W-1:0] row_pos    = '0;
    logic [DEF_CNT_W-1:0] pass_count = '0;
    logic [DEF_SUM_W-1:0] col_sum    = '0;
    logic [DEF_SUM_W-1:0] row_sum    = '0;

    pixel_t    pending_pixels[$];
    centroid_t expected_centroids[$];
    pixel_t    on_wire;

    int send_idle_pct     = 0;
    int recv_stall_pct    = 0;
    int send_burst        = 0;
    int recv_burst        = 0;
    int pixels_sent       = 0;
    int frames_sent       = 0;
    int centroids_checked = 0;
    int errors            = 0;
    int items_queued      = 0;

    threshold_centroid_tracker dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_blue        (s_blue),
        .s_green       (s_green),
        .s_red         (s_red),
        .s_end_of_line (s_end_of_line),
        .s_end_of_frame(s_end_of_frame),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_centroid_x  (m_centroid_x),
        .m_centroid_y  (m_centroid_y)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int gray_of(pixel_t px);
        return (1868 * px.blue + 9617 * px.green + 4899 * px.red + 8192) >> 14;
    endfunction

    task automatic track_pixel(input pixel_t px);
        centroid_t c;
        if (gray_of(px) > int'(gray_thr) && pass_count < PASS_CAP) begin
            pass_count = pass_count + 1'b1;
            col_sum    = col_sum + col_pos;
            row_sum    = row_sum + row_pos;
        end
        if (px.end_of_frame) begin
            if (pass_count == 0) begin
                c.x = NO_OBJECT;
                c.y = NO_OBJECT;
            end else begin
                c.x = OUT_W'(col_sum / pass_count);
                c.y = OUT_W'(row_sum / pass_count);
            end
            expected_centroids.push_back(c);
            frames_sent++;
            col_pos    = '0;
            row_pos    = '0;
            pass_count = '0;
            col_sum    = '0;
            row_sum    = '0;
        end else if (px.end_of_line) begin
            col_pos = '0;
            if (row_pos < ROW_LAST) begin
                row_pos = row_pos + 1'b1;
            end
        end else if (col_pos < COL_LAST) begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    function automatic pixel_t make_pixel(shade_t shade, logic eol, logic eof);
        pixel_t px;
        int     v;
        if (shade == SHADE_MIXED) begin
            shade = shade_t'($urandom_range(0, 3));
        end
        case (shade)
            SHADE_NEAR: begin
                v = int'(gray_thr) + int'($urandom_range(0, 2)) - 1;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                px.blue  = PIX_W'(v);
                px.green = PIX_W'(v);
                px.red   = PIX_W'(v);
            end
            SHADE_EXTREME: begin
                px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            SHADE_DARK: begin
                px.blue  = PIX_W'($urandom_range(0, 40));
                px.green = PIX_W'($urandom_range(0, 40));
                px.red   = PIX_W'($urandom_range(0, 40));
            end
            default: begin
                px.blue  = PIX_W'($urandom_range(0, 255));
                px.green = PIX_W'($urandom_range(0, 255));
                px.red   = PIX_W'($urandom_range(0, 255));
            end
        endcase
        px.end_of_line  = eol;
        px.end_of_frame = eof;
        return px;
    endfunction

    // Most frames are regular rasters; the rest carry line marks at random places.
    task automatic queue_frame();
        int     w;
        int     h;
        int     n;
        logic   last_eol;
        shade_t shade;
        shade = shade_t'($urandom_range(0, 4));
        if ($urandom_range(0, 3) != 0) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            h = $urandom_range(1, 4);
            last_eol = 1'($urandom_range(0, 1));
            for (int r = 0; r < h; r++) begin
                for (int c = 0; c < w; c++) begin
                    pending_pixels.push_back(make_pixel(shade,
                        c == w - 1 && (r != h - 1 || last_eol), r == h - 1 && c == w - 1));
                    items_queued++;
                end
            end
        end else begin
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++) begin
                pending_pixels.push_back(make_pixel(shade, $urandom_range(0, 3) == 0, i == n - 1));
                items_queued++;
            end
        end
    endtask

    task automatic set_threshold(input logic [PIX_W-1:0] thr);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= thr;
        gray_thr     = thr;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while (pending_pixels.size() != 0 || s_valid) begin
            @(negedge aclk);
        end
        while (expected_centroids.size() != 0 && waited < 20000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (64) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [PIX_W-1:0] thr, input int send_pct,
                             input int recv_pct, input int n_items);
        drain();
        set_threshold(thr);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        items_queued   = 0;
        while (items_queued < n_items) begin
            queue_frame();
        end
    endtask

    task automatic note_wrong(input string what, input logic [OUT_W-1:0] want,
                              input logic [OUT_W-1:0] got);
        errors++;
        if (errors <= 10) begin
            $display("Centroid %0d, %s: expected %0d, got %0d", centroids_checked, what,
                     $signed(want), $signed(got));
        end
    endtask

    always @(posedge aclk) begin : drive_pixels
        pixel_t nxt;
        bit     idle;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_pixel(on_wire);
                pixels_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_burst > 0) begin
                    send_burst--;
                    idle = 1'b0;
                end else begin
                    if ($urandom_range(0, 63) == 0) send_burst = $urandom_range(10, 50);
                    idle = $urandom_range(0, 99) < send_idle_pct;
                end
                if (pending_pixels.size() != 0 && !idle) begin
                    nxt = pending_pixels.pop_front();
                    on_wire = nxt;
                    s_valid        <= 1'b1;
                    s_blue         <= nxt.blue;
                    s_green        <= nxt.green;
                    s_red          <= nxt.red;
                    s_end_of_line  <= nxt.end_of_line;
                    s_end_of_frame <= nxt.end_of_frame;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_centroids
        centroid_t want;
        bit        stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                centroids_checked++;
                if (expected_centroids.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("Centroid %0d arrived with no frame ended: x %0d, y %0d",
                                 centroids_checked, m_centroid_x, m_centroid_y);
                    end
                end else begin
                    want = expected_centroids.pop_front();
                    if (m_centroid_x !== want.x) note_wrong("x", want.x, m_centroid_x);
                    if (m_centroid_y !== want.y) note_wrong("y", want.y, m_centroid_y);
                end
            end
            if (recv_burst > 0) begin
                recv_burst--;
                stall = 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0) recv_burst = $urandom_range(10, 50);
                stall = $urandom_range(0, 99) < recv_stall_pct;
            end
            m_ready <= !stall;
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset threshold of 200: gray on both sides of it, in one-pixel and longer frames.
        pending_pixels.push_back('{8'd255, 8'd255, 8'd255, 1'b0, 1'b1});
        pending_pixels.push_back('{8'd0, 8'd0, 8'd0, 1'b0, 1'b1});
        pending_pixels.push_back('{8'd200, 8'd200, 8'd200, 1'b0, 1'b1});
        pending_pixels.push_back('{8'd201, 8'd201, 8'd201, 1'b1, 1'b1});
        pending_pixels.push_back('{8'd0, 8'd255, 8'd255, 1'b0, 1'b0});
        pending_pixels.push_back('{8'd255, 8'd0, 8'd0, 1'b0, 1'b0});
        pending_pixels.push_back('{8'd0, 8'd0, 8'd255, 1'b1, 1'b0});
        pending_pixels.push_back('{8'd0, 8'd255, 8'd0, 1'b0, 1'b0});
        pending_pixels.push_back('{8'd255, 8'd255, 8'd0, 1'b0, 1'b0});
        pending_pixels.push_back('{8'd255, 8'd255, 8'd255, 1'b1, 1'b0});
        pending_pixels.push_back('{8'd128, 8'd128, 8'd128, 1'b0, 1'b0});
        pending_pixels.push_back('{8'd202, 8'd202, 8'd202, 1'b0, 1'b0});
        pending_pixels.push_back('{8'd255, 8'd255, 8'd255, 1'b0, 1'b1});
        pending_pixels.push_back('{8'd255, 8'd255, 8'd255, 1'b1, 1'b0});
        pending_pixels.push_back('{8'd10, 8'd20, 8'd30, 1'b0, 1'b0});
        pending_pixels.push_back('{8'd255, 8'd255, 8'd255, 1'b0, 1'b1});

        run_phase(8'd0, 0, 0, 120);
        run_phase(8'd255, 50, 0, 100);
        run_phase(8'd128, 0, 50, 150);
        run_phase(PIX_W'($urandom_range(1, 254)), 22, 22, 130);
        run_phase(PIX_W'($urandom_range(1, 254)), 0, 0, 50);
        drain();

        if (expected_centroids.size() != 0) begin
            errors += expected_centroids.size();
            $display("%0d expected centroids never arrived", expected_centroids.size());
        end
        $display("Sent %0d pixels in %0d frames of mixed shapes and brightness;",
                 pixels_sent, frames_sent);
        $display("checked %0d centroids over six threshold settings and four idling patterns.",
                 centroids_checked);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
